>>> design/cjtpd_pkg.sv
// ----------------------------------------------------------------------------
// cjtpd_pkg
// Shared types, register indexes, control word layout and saturation helper
// for the cubic joint trajectory PD tracker.
// ----------------------------------------------------------------------------
package cjtpd_pkg;

	// request kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_DURATION = 2'd2;

	localparam logic [15:0] DURATION_RESET = 16'd1000;

	// rate scaling: 6 from the cubic derivative, 1000 from ms to s
	localparam logic signed [19:0] RATE_SCALE = 20'sd6000;

	// width used by the saturating helper
	localparam int SAT_W = 40;

	// input request
	typedef struct packed {
		logic               kind;
		logic [1:0]         joint;
		logic [31:0]        now;
		logic signed [15:0] joint_angle;
		logic signed [15:0] joint_rate;
		logic signed [15:0] gravity_torque;
		logic signed [15:0] target_angle;
	} item_t;

	// output request
	typedef struct packed {
		logic signed [15:0] torque;
		logic signed [15:0] desired_angle;
		logic signed [15:0] desired_rate;
		logic               finished;
	} result_t;

	// gains seen by the datapath
	typedef struct packed {
		logic [15:0] kp;
		logic [15:0] kv;
	} gains_t;

	// per-request operands captured when a control step is taken
	typedef struct packed {
		logic               fin;
		logic [15:0]        t;
		logic [15:0]        span;
		logic signed [16:0] delta;
		logic signed [15:0] base;
		logic signed [15:0] angle;
		logic signed [15:0] rate;
		logic signed [15:0] grav;
	} job_t;

	// datapath status fed back to the sequencer
	typedef struct packed {
		logic fin;
		logic div_busy;
	} stat_t;

	// control word fields
	typedef logic [4:0] step_t;

	typedef enum logic [2:0] {
		MA_S, MA_S2, MA_ABSD, MA_D, MA_K6, MA_ERR_ANGLE, MA_ERR_RATE
	} mul_a_t;

	typedef enum logic [2:0] {
		MB_S, MB_SIXK, MB_SHAPE, MB_SPREAD, MB_KP, MB_KV
	} mul_b_t;

	typedef enum logic [3:0] {
		LD_NONE, LD_S, LD_S2, LD_S3, LD_K6, LD_MSCALED, LD_QD,
		LD_ACC_INIT, LD_DQD, LD_ACC_ADD
	} load_t;

	typedef enum logic [1:0] {
		DIV_NONE, DIV_PHASE, DIV_RATE
	} div_t;

	typedef enum logic [1:0] {
		BR_NONE, BR_FIN, BR_DIV_BUSY
	} branch_t;

	typedef enum logic [1:0] {
		EMIT_NONE, EMIT_TRACK, EMIT_FINISHED
	} emit_t;

	typedef struct packed {
		logic    mul_en;
		mul_a_t  mul_a;
		mul_b_t  mul_b;
		load_t   load;
		div_t    div;
		branch_t branch;
		step_t   target;
		emit_t   emit;
	} ctl_t;

	localparam ctl_t CTL_IDLE = '{
		mul_en: 1'b0, mul_a: MA_S, mul_b: MB_S, load: LD_NONE,
		div: DIV_NONE, branch: BR_NONE, target: 5'd0, emit: EMIT_NONE
	};

	// clamp a wide signed value to 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
		logic signed [15:0] r;
		if (v > SAT_W'(32767))
			r = 16'sh7FFF;
		else if (v < -SAT_W'(32768))
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

>>> design/cubic_joint_trajectory_pd_tracker_top.sv
// ----------------------------------------------------------------------------
// cubic_joint_trajectory_pd_tracker_top
// Per-joint rest-to-rest cubic trajectory with PD tracking and gravity
// feed-forward, run by a microcoded sequencer over a shared datapath.
// ----------------------------------------------------------------------------
// A start request latches, for its joint, the current tick, the measured
// angle, the distance to the goal and the configured duration; it gives
// no result. A control step request returns one result. When the joint is
// out of range, was never started or the move is over, the result is
// gravity compensation alone, handed to the output register by the
// sequencer's finish step straight after its entry step. While a move is in
// progress a step runs two passes through the shared radix-2 divider
// (normalised time, then rate scaling) and sequencing steps around the one
// shared 32x20 multiplier. A result that finds the output register still
// held waits at its emit step until the register is free. A new request is
// taken as soon as the sequencer has handed its result to the output
// register, even while that result still waits to be taken.
// ----------------------------------------------------------------------------
module cubic_joint_trajectory_pd_tracker_top #(
	parameter int JOINTS = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  cjtpd_pkg::item_t                      item,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output cjtpd_pkg::result_t                    result,
	input  logic                                  cfg_write,
	input  logic [cjtpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [15:0]                           cfg_data
);
	import cjtpd_pkg::*;

	localparam int JIW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	// configuration
	logic [15:0] kp_q;
	logic [15:0] kv_q;
	logic [15:0] dur_q;

	// per-joint trajectory state
	logic [JOINTS-1:0]  tracking_q;
	logic [31:0]        start_q [JOINTS];
	logic signed [15:0] base_q  [JOINTS];
	logic signed [16:0] dist_q  [JOINTS];
	logic [15:0]        span_q  [JOINTS];

	logic               accept;
	logic               joint_ok;
	logic [JIW-1:0]     jidx;
	logic [31:0]        elapsed;
	logic [15:0]        span_rd;
	logic               late;
	job_t               job;
	gains_t             gains;
	logic               step_go;

	ctl_t               ctl;
	stat_t              stat;
	result_t            res;
	logic               seq_busy;
	logic               out_free;
	logic               emit_now;

	logic               result_valid_q;
	result_t            result_q;

	assign accept   = item_valid && !item_stall;
	assign joint_ok = 32'(item.joint) < JOINTS;
	assign jidx     = JIW'(item.joint);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q  <= '0;
			kv_q  <= '0;
			dur_q <= DURATION_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_POSITION_GAIN: kp_q  <= cfg_data;
				REG_RATE_GAIN:     kv_q  <= cfg_data;
				REG_MOVE_DURATION: dur_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// start requests: tracking flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= '0;
		end else if (accept && item.kind == KIND_START && joint_ok) begin
			tracking_q[jidx] <= 1'b1;
		end
	end

	// start requests: trajectory values
	always_ff @(posedge clk) begin
		if (accept && item.kind == KIND_START && joint_ok) begin
			start_q[jidx] <= item.now;
			base_q[jidx]  <= item.joint_angle;
			dist_q[jidx]  <= {item.target_angle[15], item.target_angle}
			               - {item.joint_angle[15], item.joint_angle};
			span_q[jidx]  <= (dur_q == 16'd0) ? 16'd1 : dur_q;
		end
	end

	// elapsed time and move-over test for a step request
	assign elapsed = item.now - start_q[jidx];
	assign span_rd = span_q[jidx];
	assign late    = elapsed > {16'd0, span_rd};

	assign job.fin   = !joint_ok || !tracking_q[jidx] || late;
	assign job.t     = elapsed[15:0];
	assign job.span  = span_rd;
	assign job.delta = dist_q[jidx];
	assign job.base  = base_q[jidx];
	assign job.angle = item.joint_angle;
	assign job.rate  = item.joint_rate;
	assign job.grav  = item.gravity_torque;

	assign gains.kp = kp_q;
	assign gains.kv = kv_q;

	assign step_go    = accept && item.kind == KIND_STEP;
	assign item_stall = seq_busy;

	cjtpd_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (step_go),
		.stat     (stat),
		.out_free (out_free),
		.ctl      (ctl),
		.busy     (seq_busy)
	);

	cjtpd_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step_go),
		.job    (job),
		.gains  (gains),
		.ctl    (ctl),
		.stat   (stat),
		.res    (res)
	);

	// output register
	assign out_free = !result_valid_q || !result_stall;
	assign emit_now = (ctl.emit != EMIT_NONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= emit_now;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now)
			result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// a control step keeps the sequencer busy on the following cycle
	a_step_occupies: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.kind == KIND_STEP) |=> item_stall)
		else $error("control step did not occupy the sequencer");

	// a start request never produces a result
	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.kind == KIND_START && !result_valid)
		|=> !result_valid)
		else $error("start request produced a result");

	// gravity-only results carry no trajectory
	a_finished_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.finished)
		|-> (result.desired_angle == 16'sd0 && result.desired_rate == 16'sd0))
		else $error("finished result carries a trajectory");
`endif

endmodule

>>> design/cjtpd_divider.sv
// ----------------------------------------------------------------------------
// cjtpd_divider
// Radix-2 restoring divider, one quotient bit per cycle, 32 quotient bits per pass.
// ----------------------------------------------------------------------------
module cjtpd_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] num,
	input  logic [15:0] den,
	output logic        busy,
	output logic [31:0] quo
);
	import cjtpd_pkg::*;

	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [31:0] num_q;
	logic [31:0] quo_q;
	logic [15:0] rem_q;
	logic [15:0] den_q;

	logic [16:0] trial;
	logic        fits;

	// trial subtract of the next numerator bit
	assign trial = {rem_q, num_q[31]};
	assign fits  = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31)
				busy_q <= 1'b0;
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], fits};
			if (fits)
				rem_q <= 16'(trial - {1'b0, den_q});
			else
				rem_q <= trial[15:0];
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

>>> design/cjtpd_sequencer.sv
// ----------------------------------------------------------------------------
// cjtpd_sequencer
// Step counter and control store; issues one control word per cycle and
// takes jumps on the datapath status.
// ----------------------------------------------------------------------------
module cjtpd_sequencer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cjtpd_pkg::stat_t stat,
	input  logic             out_free,
	output cjtpd_pkg::ctl_t  ctl,
	output logic             busy
);
	import cjtpd_pkg::*;

	// program labels
	localparam step_t STEP_ENTRY     = 5'd0;
	localparam step_t STEP_DIV_PHASE = 5'd1;
	localparam step_t STEP_WAIT_S    = 5'd2;
	localparam step_t STEP_LD_S      = 5'd3;
	localparam step_t STEP_SQ        = 5'd4;
	localparam step_t STEP_CUBE      = 5'd5;
	localparam step_t STEP_SPREAD    = 5'd6;
	localparam step_t STEP_SHAPE     = 5'd7;
	localparam step_t STEP_SCALE     = 5'd8;
	localparam step_t STEP_QD        = 5'd9;
	localparam step_t STEP_ERR_ANGLE = 5'd10;
	localparam step_t STEP_ACC_INIT  = 5'd11;
	localparam step_t STEP_WAIT_RATE = 5'd12;
	localparam step_t STEP_DQD       = 5'd13;
	localparam step_t STEP_ERR_RATE  = 5'd14;
	localparam step_t STEP_ACC_ADD   = 5'd15;
	localparam step_t STEP_EMIT      = 5'd16;
	localparam step_t STEP_FIN       = 5'd17;

	// control store
	function automatic ctl_t ucode(input step_t pc);
		ctl_t w;
		w = CTL_IDLE;
		case (pc)
			STEP_ENTRY: begin
				w.branch = BR_FIN;
				w.target = STEP_FIN;
			end
			STEP_DIV_PHASE: begin
				w.div = DIV_PHASE;
			end
			STEP_WAIT_S: begin
				w.branch = BR_DIV_BUSY;
				w.target = STEP_WAIT_S;
			end
			STEP_LD_S: begin
				w.load = LD_S;
			end
			STEP_SQ: begin
				w.mul_en = 1'b1;
				w.mul_a  = MA_S;
				w.mul_b  = MB_S;
			end
			STEP_CUBE: begin
				w.load   = LD_S2;
				w.mul_en = 1'b1;
				w.mul_a  = MA_ABSD;
				w.mul_b  = MB_SIXK;
			end
			STEP_SPREAD: begin
				w.load   = LD_K6;
				w.mul_en = 1'b1;
				w.mul_a  = MA_S2;
				w.mul_b  = MB_S;
			end
			STEP_SHAPE: begin
				w.load   = LD_S3;
				w.mul_en = 1'b1;
				w.mul_a  = MA_K6;
				w.mul_b  = MB_SPREAD;
			end
			STEP_SCALE: begin
				w.load   = LD_MSCALED;
				w.mul_en = 1'b1;
				w.mul_a  = MA_D;
				w.mul_b  = MB_SHAPE;
			end
			STEP_QD: begin
				w.load = LD_QD;
				w.div  = DIV_RATE;
			end
			STEP_ERR_ANGLE: begin
				w.mul_en = 1'b1;
				w.mul_a  = MA_ERR_ANGLE;
				w.mul_b  = MB_KP;
			end
			STEP_ACC_INIT: begin
				w.load = LD_ACC_INIT;
			end
			STEP_WAIT_RATE: begin
				w.branch = BR_DIV_BUSY;
				w.target = STEP_WAIT_RATE;
			end
			STEP_DQD: begin
				w.load = LD_DQD;
			end
			STEP_ERR_RATE: begin
				w.mul_en = 1'b1;
				w.mul_a  = MA_ERR_RATE;
				w.mul_b  = MB_KV;
			end
			STEP_ACC_ADD: begin
				w.load = LD_ACC_ADD;
			end
			STEP_EMIT: begin
				w.emit = EMIT_TRACK;
			end
			STEP_FIN: begin
				w.emit = EMIT_FINISHED;
			end
			default: begin
				w = CTL_IDLE;
			end
		endcase
		return w;
	endfunction

	logic  active_q;
	step_t pc_q;
	ctl_t  word;

	assign word = ucode(pc_q);
	assign ctl  = active_q ? word : CTL_IDLE;
	assign busy = active_q;

	// step counter with jumps; an emit step holds until the output is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pc_q     <= STEP_ENTRY;
		end else if (start) begin
			active_q <= 1'b1;
			pc_q     <= STEP_ENTRY;
		end else if (active_q) begin
			case (word.branch)
				BR_FIN: begin
					pc_q <= stat.fin ? word.target : pc_q + 5'd1;
				end
				BR_DIV_BUSY: begin
					pc_q <= stat.div_busy ? word.target : pc_q + 5'd1;
				end
				default: begin
					if (word.emit != EMIT_NONE) begin
						if (out_free)
							active_q <= 1'b0;
					end else begin
						pc_q <= pc_q + 5'd1;
					end
				end
			endcase
		end
	end

endmodule

>>> design/cjtpd_datapath.sv
// ----------------------------------------------------------------------------
// cjtpd_datapath
// Operand registers, one shared signed multiplier with a product register and
// the shared divider, steered by the sequencer's control word.
// ----------------------------------------------------------------------------
module cjtpd_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  cjtpd_pkg::job_t    job,
	input  cjtpd_pkg::gains_t  gains,
	input  cjtpd_pkg::ctl_t    ctl,
	output cjtpd_pkg::stat_t   stat,
	output cjtpd_pkg::result_t res
);
	import cjtpd_pkg::*;

	// captured request operands
	logic               fin_q;
	logic [15:0]        t_q;
	logic [15:0]        span_q;
	logic signed [16:0] d_q;
	logic signed [15:0] base_q;
	logic signed [15:0] ang_q;
	logic signed [15:0] rate_q;
	logic signed [15:0] grav_q;

	// working registers
	logic [16:0]        s_q;
	logic [16:0]        s2_q;
	logic [16:0]        s3_q;
	logic [28:0]        k6_q;
	logic [25:0]        mscaled_q;
	logic signed [15:0] qd_q;
	logic signed [15:0] dqd_q;
	logic signed [36:0] acc_q;
	logic signed [51:0] prod_q;

	logic signed [31:0] op_a;
	logic signed [19:0] op_b;
	logic signed [51:0] prod_d;

	logic [16:0]        absd;
	logic [16:0]        spread;
	logic [18:0]        shape;
	logic signed [16:0] err_ang;
	logic signed [16:0] err_rate;
	logic [43:0]        msum;
	logic signed [51:0] qd_round;
	logic signed [SAT_W-1:0] qd_sum;
	logic signed [SAT_W-1:0] tau_sum;
	logic [25:0]        rate_quo;
	logic signed [15:0] dqd_d;

	logic        div_go;
	logic [31:0] div_num;
	logic        div_busy;
	logic [31:0] div_quo;

	// derived operands
	assign absd     = d_q[16] ? 17'(-d_q) : d_q;
	assign spread   = s_q - s2_q;
	assign shape    = ({2'b00, s2_q} + {1'b0, s2_q, 1'b0}) - {1'b0, s3_q, 1'b0};
	assign err_ang  = {ang_q[15], ang_q} - {qd_q[15], qd_q};
	assign err_rate = {rate_q[15], rate_q} - {dqd_q[15], dqd_q};

	// multiplier operand selection
	always_comb begin
		case (ctl.mul_a)
			MA_S:         op_a = {15'd0, s_q};
			MA_S2:        op_a = {15'd0, s2_q};
			MA_ABSD:      op_a = {15'd0, absd};
			MA_D:         op_a = {{15{d_q[16]}}, d_q};
			MA_K6:        op_a = {3'd0, k6_q};
			MA_ERR_ANGLE: op_a = {{15{err_ang[16]}}, err_ang};
			MA_ERR_RATE:  op_a = {{15{err_rate[16]}}, err_rate};
			default:      op_a = '0;
		endcase
	end

	always_comb begin
		case (ctl.mul_b)
			MB_S:      op_b = {3'd0, s_q};
			MB_SIXK:   op_b = RATE_SCALE;
			MB_SHAPE:  op_b = {1'b0, shape};
			MB_SPREAD: op_b = {3'd0, spread};
			MB_KP:     op_b = {4'd0, gains.kp};
			MB_KV:     op_b = {4'd0, gains.kv};
			default:   op_b = '0;
		endcase
	end

	assign prod_d = op_a * op_b;

	// divider shared between normalised time and rate scaling
	assign div_go  = ctl.div != DIV_NONE;
	assign div_num = (ctl.div == DIV_PHASE) ? {t_q, 16'd0} : {6'd0, mscaled_q};

	cjtpd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (span_q),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// rounding bias for the rate division, then drop the 2^18 scale
	assign msum = 44'(prod_q[42:0]) + {11'd0, span_q, 17'd0};

	// desired angle: base plus rounded cubic term
	assign qd_round = (prod_q + 52'sd32768) >>> 16;
	assign qd_sum   = SAT_W'(base_q) + SAT_W'(qd_round);

	// desired rate magnitude back to signed and clamped
	assign rate_quo = div_quo[25:0];
	always_comb begin
		if (!d_q[16]) begin
			if (|rate_quo[25:15])
				dqd_d = 16'sh7FFF;
			else
				dqd_d = $signed(rate_quo[15:0]);
		end else begin
			if (|rate_quo[25:15])
				dqd_d = 16'sh8000;
			else
				dqd_d = $signed(16'(16'd0 - rate_quo[15:0]));
		end
	end

	// torque: negate, round at bit 12
	assign tau_sum = (SAT_W'(2048) - SAT_W'(acc_q)) >>> 12;

	// request capture
	always_ff @(posedge clk) begin
		if (load) begin
			fin_q  <= job.fin;
			t_q    <= job.t;
			span_q <= job.span;
			d_q    <= job.delta;
			base_q <= job.base;
			ang_q  <= job.angle;
			rate_q <= job.rate;
			grav_q <= job.grav;
		end
	end

	// product register
	always_ff @(posedge clk) begin
		if (ctl.mul_en)
			prod_q <= prod_d;
	end

	// register loads named by the control word
	always_ff @(posedge clk) begin
		case (ctl.load)
			LD_S:        s_q       <= div_quo[16:0];
			LD_S2:       s2_q      <= prod_q[32:16];
			LD_S3:       s3_q      <= prod_q[32:16];
			LD_K6:       k6_q      <= prod_q[28:0];
			LD_MSCALED:  mscaled_q <= msum[43:18];
			LD_QD:       qd_q      <= sat16(qd_sum);
			LD_ACC_INIT: acc_q     <= prod_q[36:0] + 37'({{9{grav_q[15]}}, grav_q, 12'd0});
			LD_DQD:      dqd_q     <= dqd_d;
			LD_ACC_ADD:  acc_q     <= acc_q + {prod_q[34:0], 2'b00};
			default: ;
		endcase
	end

	// result presented on emit steps
	always_comb begin
		case (ctl.emit)
			EMIT_FINISHED: begin
				res.torque        = sat16(-SAT_W'(grav_q));
				res.desired_angle = '0;
				res.desired_rate  = '0;
				res.finished      = 1'b1;
			end
			default: begin
				res.torque        = sat16(tau_sum);
				res.desired_angle = qd_q;
				res.desired_rate  = dqd_q;
				res.finished      = 1'b0;
			end
		endcase
	end

	assign stat.fin      = fin_q;
	assign stat.div_busy = div_busy;

endmodule

>>> sim/cubic_joint_trajectory_pd_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// cubic_joint_trajectory_pd_tracker_top_tb
// Self-checking bench for the joint trajectory PD tracker: start and control
// step requests go in under several gain and duration settings, and every
// torque command that comes out is matched against a bit-exact prediction.
// ----------------------------------------------------------------------------
module cubic_joint_trajectory_pd_tracker_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import cjtpd_pkg::*;

	localparam int JOINTS = 3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PHASES = 6;
	localparam int PHASE_REQUESTS = 67;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_CYCLES = 500;

	// predicted results for control steps, in request order
	class pd_command_model;
		longint kp, kv, duration;
		bit tracking[JOINTS];
		logic [31:0] start_tick[JOINTS];
		longint span[JOINTS];
		longint base[JOINTS];
		longint square_coef[JOINTS];
		longint cube_coef[JOINTS];
		result_t awaited[$];
		int errors;

		function new();
			kp = 0;
			kv = 0;
			duration = DURATION_RESET;
			errors = 0;
			foreach (tracking[j]) begin
				tracking[j] = 1'b0;
				start_tick[j] = '0;
				span[j] = 0;
				base[j] = 0;
				square_coef[j] = 0;
				cube_coef[j] = 0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				REG_POSITION_GAIN: kp = data;
				REG_RATE_GAIN:     kv = data;
				REG_MOVE_DURATION: duration = data;
				default: ;
			endcase
		endfunction

		function automatic logic signed [15:0] clamp16(longint v);
			if (v > 32767)
				return 16'sh7FFF;
			if (v < -32768)
				return 16'sh8000;
			return v[15:0];
		endfunction

		// torque command for a control step at the current state
		function automatic result_t command_for(item_t it);
			result_t r;
			bit over;
			int unsigned elapsed;
			longint t, sp, s, s2, s3, sq, cu, qd, dqd, num, den, acc, q, dq, g;
			q = it.joint_angle;
			dq = it.joint_rate;
			g = it.gravity_torque;
			over = 1'b1;
			if (it.joint < JOINTS && tracking[it.joint]) begin
				elapsed = it.now - start_tick[it.joint];
				over = elapsed > span[it.joint];
			end
			if (over) begin
				r.torque = clamp16(-g);
				r.desired_angle = '0;
				r.desired_rate = '0;
				r.finished = 1'b1;
				return r;
			end
			t = elapsed;
			sp = span[it.joint];
			sq = square_coef[it.joint];
			cu = cube_coef[it.joint];
			// normalised time and its powers, all Q16
			s = (t << 16) / sp;
			s2 = (s * s) >>> 16;
			s3 = (s2 * s) >>> 16;
			qd = clamp16(base[it.joint] + ((sq * s2 + cu * s3 + 32768) >>> 16));
			// rate: Q3.12 per tick to Q5.10 per second, round half away from zero
			num = (2 * sq * s + 3 * cu * s2) * 1000;
			den = sp << 18;
			if (num >= 0)
				dqd = clamp16((num + den / 2) / den);
			else
				dqd = clamp16(-((-num + den / 2) / den));
			acc = kp * (q - qd) + 4 * kv * (dq - dqd) + 4096 * g;
			r.torque = clamp16((-acc + 2048) >>> 12);
			r.desired_angle = qd[15:0];
			r.desired_rate = dqd[15:0];
			r.finished = 1'b0;
			return r;
		endfunction

		function void note_request(item_t it);
			int d;
			if (it.kind == KIND_START) begin
				if (it.joint < JOINTS) begin
					d = int'(it.target_angle) - int'(it.joint_angle);
					tracking[it.joint] = 1'b1;
					start_tick[it.joint] = it.now;
					base[it.joint] = it.joint_angle;
					square_coef[it.joint] = 3 * d;
					cube_coef[it.joint] = -2 * d;
					span[it.joint] = (duration == 0) ? 1 : duration;
				end
			end else begin
				awaited.push_back(command_for(it));
			end
		endfunction

		function void compare(string name, longint want, longint got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_command(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				$error("unexpected result: torque %0d", got.torque);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare("torque", want.torque, got.torque);
			compare("desired_angle", want.desired_angle, got.desired_angle);
			compare("desired_rate", want.desired_rate, got.desired_rate);
			compare("finished", want.finished, got.finished);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	pd_command_model sb = new();
	int stall_mode = 1;
	int max_gap = 3;
	int burst_left = 0;
	int hold_asks = 0;

	cubic_joint_trajectory_pd_tracker_top #(
		.JOINTS(JOINTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#5ms;
		$display("** cubic_joint_trajectory_pd_tracker_top: FAILED **");
		$finish;
	end

	// receiver: take results and stall in its own pattern
	initial begin
		int hold_seen;
		int hold_left;
		int cyc;
		hold_seen = 0;
		hold_left = 0;
		cyc = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				sb.check_command(result);
			cyc++;
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				case (stall_mode)
					1: result_stall <= ($urandom_range(0, 3) == 0);
					2: result_stall <= (cyc % 6 >= 4);
					3: result_stall <= ($urandom_range(0, 3) != 0);
					default: result_stall <= 1'b0;
				endcase
			end
		end
	end

	function automatic item_t req(logic kind, logic [1:0] joint, logic [31:0] now,
			int q, int dq, int g, int tgt);
		item_t it;
		it.kind = kind;
		it.joint = joint;
		it.now = now;
		it.joint_angle = q[15:0];
		it.joint_rate = dq[15:0];
		it.gravity_torque = g[15:0];
		it.target_angle = tgt[15:0];
		return it;
	endfunction

	// offer one request in bursts with random gaps, return once it is taken
	task automatic offer(item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, max_gap);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		sb.note_request(it);
	endtask

	// wait for every awaited command, then let the block go quiet
	task automatic settle();
		item_valid <= 1'b0;
		burst_left = 0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(logic [15:0] kp, logic [15:0] kv, logic [15:0] dur);
		write_reg(REG_UNUSED, 16'($urandom));
		write_reg(REG_POSITION_GAIN, kp);
		write_reg(REG_RATE_GAIN, kv);
		write_reg(REG_MOVE_DURATION, dur);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// mostly well-formed moves and steps inside them, some noise
	function automatic item_t random_request();
		item_t it;
		int r;
		int j;
		int unsigned t;
		it = req(KIND_STEP, 2'd0, $urandom, $urandom, $urandom, $urandom, $urandom);
		r = $urandom_range(0, 99);
		if (r < 15) begin
			it.kind = KIND_START;
			it.joint = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
			if ($urandom_range(0, 1))
				it.target_angle = it.joint_angle + 16'($urandom_range(0, 8192) - 4096);
		end else if (r < 88) begin
			j = $urandom_range(0, JOINTS - 1);
			it.joint = 2'(j);
			if (sb.tracking[j]) begin
				case ($urandom_range(0, 9))
					0: t = 0;
					1: t = 32'(sb.span[j]);
					2: t = 32'(sb.span[j] + 1);
					default: t = $urandom_range(0, 32'(sb.span[j]));
				endcase
				it.now = sb.start_tick[j] + t;
				if ($urandom_range(0, 1)) begin
					it.joint_angle = 16'(sb.base[j]) + 16'($urandom_range(0, 2048) - 1024);
					it.joint_rate = 16'($urandom_range(0, 2048) - 1024);
					it.gravity_torque = 16'($urandom_range(0, 4096) - 2048);
				end
			end
		end else begin
			it.joint = 2'($urandom_range(0, 3));
		end
		return it;
	endfunction

	// stimulus
	initial begin
		int phase;
		int n;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: never started, joint out of range, full-scale move at reset gains
		offer(req(KIND_STEP, 2'd0, 32'd10, 0, 0, -32768, 0));
		offer(req(KIND_STEP, 2'd3, 32'hFFFF_FFFF, 32767, -32768, 32767, 0));
		offer(req(KIND_START, 2'd3, 32'd5, 100, 0, 0, 2000));
		offer(req(KIND_STEP, 2'd3, 32'd5, 100, 0, 5, 0));
		offer(req(KIND_START, 2'd0, 32'hFFFF_FF00, -32768, 0, 0, 32767));
		offer(req(KIND_STEP, 2'd0, 32'hFFFF_FF00, -32768, 32767, 0, 0));
		offer(req(KIND_STEP, 2'd0, 32'hFFFF_FF00 + 500, 0, 0, 100, 0));
		offer(req(KIND_STEP, 2'd0, 32'hFFFF_FF00 + 1000, 32767, -32768, -100, 0));
		offer(req(KIND_STEP, 2'd0, 32'hFFFF_FF00 + 1001, 0, 0, 32767, 0));
		settle();

		// maximum gains, zero duration taken as one tick
		configure(16'hFFFF, 16'hFFFF, 16'h0000);
		offer(req(KIND_START, 2'd1, 32'd100, 32767, 0, 0, -32768));
		offer(req(KIND_STEP, 2'd1, 32'd100, 0, -32768, -32768, 0));
		offer(req(KIND_STEP, 2'd1, 32'd101, -32768, 32767, 32767, 0));
		offer(req(KIND_STEP, 2'd1, 32'd102, 0, 0, 1, 0));
		// joint 0 keeps its latched duration
		offer(req(KIND_STEP, 2'd0, 32'hFFFF_FF00 + 999, 32767, 32767, 0, 0));
		settle();

		// longest duration, moderate gains, then a move of zero distance
		configure(16'h00C0, 16'h0040, 16'hFFFF);
		offer(req(KIND_START, 2'd2, 32'd0, 0, 0, 0, 16384));
		offer(req(KIND_STEP, 2'd2, 32'd32768, 8000, 100, -50, 0));
		offer(req(KIND_STEP, 2'd2, 32'd65535, 16384, 0, 0, 0));
		offer(req(KIND_STEP, 2'd2, 32'd65536, 16384, 0, 0, 0));
		offer(req(KIND_START, 2'd2, 32'hFFFF_FFFF, 12000, 0, 0, 12000));
		offer(req(KIND_STEP, 2'd2, 32'h7FFF_FFFF, 12000, 0, 0, 0));
		settle();

		// random phases, each under its own setting and idling pattern
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: configure(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
					16'($urandom_range(1, 200)));
				1: configure(16'hFFFF, 16'h0000, 16'h0000);
				2: configure(16'h0000, 16'hFFFF, 16'hFFFF);
				3: configure(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
				4: configure(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 1024)),
					DURATION_RESET);
				default: configure(16'($urandom_range(0, 4096)),
					16'($urandom_range(0, 4096)), 16'($urandom_range(2, 20)));
			endcase
			stall_mode = phase % 4;
			max_gap = (phase == 0) ? 0 : $urandom_range(2, 8);
			if (phase == 4)
				hold_asks++;
			for (n = 0; n < PHASE_REQUESTS; n++)
				offer(random_request());
			settle();
		end

		if (sb.errors == 0)
			$display("** cubic_joint_trajectory_pd_tracker_top: PASSED **");
		else
			$display("** cubic_joint_trajectory_pd_tracker_top: FAILED **");
		$finish;
	end

endmodule
